>>> src/wmam_pkg.sv
// Shared types and constants for the management frame attack monitor.
package wmam_pkg;

  localparam int unsigned TableEntries = 8;
  localparam int unsigned SsidMaxBytes = 32;
  localparam int unsigned SsidWords = SsidMaxBytes / 8;
  localparam int unsigned TabIdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned SeenCntW = $clog2(TableEntries + 1);
  localparam int unsigned SsidBits = SsidMaxBytes * 8;

  // Element walk phases.
  typedef enum logic [2:0] {
    PH_ID        = 3'd0,
    PH_LEN       = 3'd1,
    PH_SSID_LEN  = 3'd2,
    PH_SKIP      = 3'd3,
    PH_SSID_BODY = 3'd4,
    PH_DONE      = 3'd5
  } phase_e;

  // Frame kinds.
  localparam logic [2:0] KindDeauth   = 3'd0;
  localparam logic [2:0] KindDisassoc = 3'd1;
  localparam logic [2:0] KindProbe    = 3'd2;
  localparam logic [2:0] KindBeacon   = 3'd3;
  localparam logic [2:0] KindOther    = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] RegWindow = 2'd0;
  localparam logic [1:0] RegDeauth = 2'd1;
  localparam logic [1:0] RegBeacon = 2'd2;

  // Alert bits.
  localparam logic [3:0] AlertBcast  = 4'b0001;
  localparam logic [3:0] AlertDflood = 4'b0010;
  localparam logic [3:0] AlertBflood = 4'b0100;
  localparam logic [3:0] AlertTwin   = 4'b1000;

  // Controller to datapath commands.
  typedef struct packed {
    logic byte_en;     // consume one input beat
    logic end_latch;   // last byte: classify and update counters
    logic srch_start;  // reset table search pointer
    logic srch_step;   // compare one table entry
    logic finish;      // commit table result, load output register
  } dp_cmd_t;

  // Datapath status for the controller.
  typedef struct packed {
    logic need_search; // accepted beacon with usable SSID
    logic srch_done;   // search finished (hit or table exhausted)
  } dp_sts_t;

endpackage

>>> src/wmam_ctrl.sv
// Controller: byte intake, end-of-frame table search sequencing, output handoff.
module wmam_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              in_last_i,
  input  wmam_pkg::dp_sts_t sts_i,
  output wmam_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_BYTE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_FIN    = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   take, pop;

  assign pop         = ovalid_q && !out_stall_i;
  // Output register free once popped; a new frame end waits for that.
  assign in_stall_o  = (state_q != ST_BYTE) || (in_last_i && ovalid_q && !pop);
  assign take        = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    ovalid_d = ovalid_q && !pop;
    cmd_o = '0;
    case (state_q)
      ST_BYTE: begin
        cmd_o.byte_en = take;
        if (take && in_last_i) begin
          cmd_o.end_latch = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.srch_start = 1'b1;
        state_d = sts_i.need_search ? ST_SEARCH : ST_FIN;
      end
      ST_SEARCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.srch_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        ovalid_d = 1'b1;
        state_d = ST_BYTE;
      end
      default: state_d = ST_BYTE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BYTE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

>>> src/wmam_dp.sv
// Datapath: frame parsing, window counters, SSID table and result register.
module wmam_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [7:0]        frame_byte_i,
  input  logic [31:0]       time_seconds_i,
  input  wmam_pkg::dp_cmd_t cmd_i,
  output wmam_pkg::dp_sts_t sts_o,
  output logic              accepted_o,
  output logic [2:0]        frame_kind_o,
  output logic [3:0]        new_alerts_o,
  output logic [3:0]        held_alerts_o
);

  localparam int unsigned TE = wmam_pkg::TableEntries;
  localparam int unsigned SB = wmam_pkg::SsidBits;
  localparam int unsigned IW = wmam_pkg::TabIdxW;
  localparam int unsigned CW = wmam_pkg::SeenCntW;

  // Configuration registers
  logic [31:0] win_q;
  logic [15:0] dth_q, bth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 32'd10;
      dth_q <= 16'd8;
      bth_q <= 16'd40;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wmam_pkg::RegWindow: win_q <= cfg_data_i;
        wmam_pkg::RegDeauth: dth_q <= cfg_data_i[15:0];
        wmam_pkg::RegBeacon: bth_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Per-frame parse state
  logic [11:0]      pos_q;
  logic [7:0]       fc_q;
  logic             rx_ones_q;
  logic [47:0]      bssid_q;
  wmam_pkg::phase_e ph_q;
  logic [7:0]       rem_q;
  logic [SB-1:0]    ssid_q;
  logic             found_q;
  logic [5:0]       cap_q;

  logic [11:0]      pos;
  logic [7:0]       fc_n;
  logic             rx_n;
  logic [47:0]      bssid_n;
  wmam_pkg::phase_e ph_n;
  logic [7:0]       rem_n;
  logic [SB-1:0]    ssid_n;
  logic             found_n;
  logic [5:0]       cap_n;
  logic [7:0]       b;

  assign b = frame_byte_i;
  assign pos = pos_q;

  always_comb begin
    fc_n = fc_q; rx_n = rx_ones_q; bssid_n = bssid_q; ph_n = ph_q;
    rem_n = rem_q; ssid_n = ssid_q; found_n = found_q; cap_n = cap_q;
    if (pos == 12'd0) begin
      fc_n = b; rx_n = 1'b1; bssid_n = '0; ph_n = wmam_pkg::PH_ID;
      rem_n = '0; ssid_n = '0; found_n = 1'b0; cap_n = '0;
    end
    if (pos >= 12'd4 && pos <= 12'd9 && b != 8'hFF) rx_n = 1'b0;
    if (pos >= 12'd16 && pos <= 12'd21) begin
      case (pos[4:0])
        5'd16: bssid_n[7:0]   = b;
        5'd17: bssid_n[15:8]  = b;
        5'd18: bssid_n[23:16] = b;
        5'd19: bssid_n[31:24] = b;
        5'd20: bssid_n[39:32] = b;
        default: bssid_n[47:40] = b;
      endcase
    end
    if (pos >= 12'd36) begin
      case (ph_q)
        wmam_pkg::PH_ID: ph_n = (b == 8'd0) ? wmam_pkg::PH_SSID_LEN : wmam_pkg::PH_LEN;
        wmam_pkg::PH_LEN: begin
          rem_n = b;
          ph_n = (b != 8'd0) ? wmam_pkg::PH_SKIP : wmam_pkg::PH_ID;
        end
        wmam_pkg::PH_SSID_LEN: begin
          rem_n = b;
          cap_n = '0;
          if (b == 8'd0) begin
            found_n = 1'b1;
            ph_n = wmam_pkg::PH_DONE;
          end else begin
            ph_n = wmam_pkg::PH_SSID_BODY;
          end
        end
        wmam_pkg::PH_SKIP: begin
          rem_n = rem_q - 8'd1;
          if (rem_n == 8'd0) ph_n = wmam_pkg::PH_ID;
        end
        wmam_pkg::PH_SSID_BODY: begin
          if (!cap_q[5]) begin
            ssid_n[8*cap_q[4:0] +: 8] = ssid_q[8*cap_q[4:0] +: 8] | b;
            cap_n = cap_q + 6'd1;
          end
          rem_n = rem_q - 8'd1;
          if (rem_n == 8'd0) begin
            found_n = 1'b1;
            ph_n = wmam_pkg::PH_DONE;
          end
        end
        default: ph_n = wmam_pkg::PH_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; fc_q <= '0; rx_ones_q <= 1'b1; bssid_q <= '0;
      ph_q <= wmam_pkg::PH_ID; rem_q <= '0; ssid_q <= '0; found_q <= 1'b0;
      cap_q <= '0;
    end else if (cmd_i.byte_en) begin
      fc_q <= fc_n; rx_ones_q <= rx_n; bssid_q <= bssid_n; ph_q <= ph_n;
      rem_q <= rem_n; ssid_q <= ssid_n; found_q <= found_n; cap_q <= cap_n;
      if (cmd_i.end_latch) pos_q <= '0;
      else if (pos_q != 12'hFFF) pos_q <= pos_q + 12'd1;
    end
  end

  // Classification at the last byte
  logic       ok;
  logic [2:0] kind;
  always_comb begin
    ok = 1'b0;
    kind = wmam_pkg::KindOther;
    if (pos >= 12'd23 && fc_n[3:2] == 2'b00) begin
      ok = 1'b1;
      case (fc_n[7:4])
        4'hC: kind = wmam_pkg::KindDeauth;
        4'hA: kind = wmam_pkg::KindDisassoc;
        4'h4: kind = wmam_pkg::KindProbe;
        4'h8: kind = wmam_pkg::KindBeacon;
        default: ok = 1'b0;
      endcase
    end
  end

  // Window and counters, updated on the last byte
  logic [31:0] wstart_q, ws, win_eff;
  logic [15:0] dcnt_q, bcnt_q, dc, bc, dth_eff, bth_eff;
  logic [3:0]  alerts_q, raised_q;
  logic [3:0]  alerts_n, raised_n;

  assign win_eff = (win_q != 32'd0) ? win_q : 32'd10;
  assign dth_eff = (dth_q != 16'd0) ? dth_q : 16'd8;
  assign bth_eff = (bth_q != 16'd0) ? bth_q : 16'd40;

  logic restart;
  always_comb begin
    ws = (wstart_q == 32'd0) ? time_seconds_i : wstart_q;
    restart = (time_seconds_i - ws) >= win_eff;
    dc = dcnt_q;
    bc = bcnt_q;
    if (restart) begin
      ws = time_seconds_i; dc = '0; bc = '0;
    end
    alerts_n = alerts_q;
    raised_n = '0;
    if (kind == wmam_pkg::KindDeauth || kind == wmam_pkg::KindDisassoc) begin
      if (rx_n && !alerts_n[0]) begin
        alerts_n = alerts_n | wmam_pkg::AlertBcast; raised_n = raised_n | wmam_pkg::AlertBcast;
      end
      if (dc != 16'hFFFF) dc = dc + 16'd1;
      if (dc >= dth_eff && !alerts_n[1]) begin
        alerts_n = alerts_n | wmam_pkg::AlertDflood;
        raised_n = raised_n | wmam_pkg::AlertDflood;
      end
    end else if (kind == wmam_pkg::KindBeacon) begin
      if (bc != 16'hFFFF) bc = bc + 16'd1;
      if (bc >= bth_eff && !alerts_n[2]) begin
        alerts_n = alerts_n | wmam_pkg::AlertBflood;
        raised_n = raised_n | wmam_pkg::AlertBflood;
      end
    end
  end

  logic       ok_q;
  logic [2:0] kind_q;
  logic       need_q;
  logic       twin_set;

  // Canonical SSID: zero from the first zero byte on
  logic [SB-1:0] canon;
  logic          ended;
  always_comb begin
    ended = 1'b0;
    canon = '0;
    for (int k = 0; k < wmam_pkg::SsidMaxBytes; k++) begin
      if (ssid_q[8*k +: 8] == 8'd0) ended = 1'b1;
      if (!ended) canon[8*k +: 8] = ssid_q[8*k +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wstart_q <= '0; dcnt_q <= '0; bcnt_q <= '0; alerts_q <= '0;
      raised_q <= '0; ok_q <= 1'b0; kind_q <= wmam_pkg::KindOther; need_q <= 1'b0;
    end else if (cmd_i.end_latch) begin
      ok_q <= ok;
      kind_q <= ok ? kind : wmam_pkg::KindOther;
      need_q <= ok && kind == wmam_pkg::KindBeacon && found_n && ssid_n[7:0] != 8'd0;
      raised_q <= ok ? raised_n : 4'd0;
      if (ok) begin
        wstart_q <= ws; dcnt_q <= dc; bcnt_q <= bc; alerts_q <= alerts_n;
      end
    end else if (cmd_i.finish && twin_set) begin
      alerts_q <= alerts_q | wmam_pkg::AlertTwin;
      raised_q <= raised_q | wmam_pkg::AlertTwin;
    end
  end

  // SSID table: one entry compared per cycle
  logic [SB-1:0] tab_ssid [TE];
  logic [47:0]   tab_bssid [TE];
  logic [CW-1:0] seen_q;
  logic [CW-1:0] sp_q;
  logic          hit_q, twin_q;
  logic          at_end, cmp;

  assign at_end = (sp_q >= seen_q);
  assign cmp = !at_end && (tab_ssid[sp_q[IW-1:0]] == canon);
  assign twin_set = twin_q && !alerts_q[3];
  assign sts_o.need_search = need_q;
  assign sts_o.srch_done = at_end || hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0; sp_q <= '0; hit_q <= 1'b0; twin_q <= 1'b0;
    end else if (cmd_i.srch_start) begin
      sp_q <= '0; hit_q <= 1'b0; twin_q <= 1'b0;
    end else if (cmd_i.srch_step && !(at_end || hit_q)) begin
      if (cmp) begin
        hit_q <= 1'b1;
        twin_q <= tab_bssid[sp_q[IW-1:0]] != bssid_q;
      end else begin
        sp_q <= sp_q + 1'b1;
      end
    end else if (cmd_i.finish && need_q && !hit_q && seen_q < CW'(TE)) begin
      seen_q <= seen_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && need_q && !hit_q && seen_q < CW'(TE)) begin
      tab_ssid[seen_q[IW-1:0]] <= canon;
      tab_bssid[seen_q[IW-1:0]] <= bssid_q;
    end
  end

  // Result register
  logic       acc_oq;
  logic [2:0] kind_oq;
  logic [3:0] new_oq, held_oq;
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      acc_oq <= ok_q;
      kind_oq <= kind_q;
      new_oq <= raised_q | (twin_set ? wmam_pkg::AlertTwin : 4'd0);
      held_oq <= alerts_q | (twin_set ? wmam_pkg::AlertTwin : 4'd0);
    end
  end

  assign accepted_o = acc_oq;
  assign frame_kind_o = kind_oq;
  assign new_alerts_o = new_oq;
  assign held_alerts_o = held_oq;

endmodule

>>> src/wifi_mgmt_attack_monitor_core.sv
// Top level of the management frame attack monitor.
// Takes one frame byte per beat. A non-final byte is taken every cycle. After
// the last byte the block passes through a check state and a finish state for
// classification and result commit; for an accepted beacon with a non-empty
// SSID it also runs the table search between them, one entry compared per
// cycle until a hit or the end of the filled table. Further bytes are stalled
// meanwhile; the result beat is held in an output register until taken, and
// the next last byte waits for it to be free. Only the search varies in length.
module wifi_mgmt_attack_monitor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  input  logic [31:0] time_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [2:0]  frame_kind_o,
  output logic [3:0]  new_alerts_o,
  output logic [3:0]  held_alerts_o
);

  wmam_pkg::dp_cmd_t cmd;
  wmam_pkg::dp_sts_t sts;

  wmam_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .in_last_i(frame_end_i), .sts_i(sts), .cmd_o(cmd)
  );

  wmam_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .frame_byte_i,
    .time_seconds_i, .cmd_i(cmd), .sts_o(sts), .accepted_o, .frame_kind_o,
    .new_alerts_o, .held_alerts_o
  );

endmodule

>>> bench/testbench.sv
// Self-checking bench for the management frame attack monitor core.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 100000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = wmam_pkg::RegWindow;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  frame_byte_i = '0;
  logic        frame_end_i = 1'b0;
  logic [31:0] time_seconds_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        accepted_o;
  logic [2:0]  frame_kind_o;
  logic [3:0]  new_alerts_o;
  logic [3:0]  held_alerts_o;

  wifi_mgmt_attack_monitor_core DUT (.*);

  always #2 clk_i = ~clk_i;

  // One frame verdict as seen on the result port.
  typedef struct packed {
    logic       accepted;
    logic [2:0] kind;
    logic [3:0] fresh;
    logic [3:0] held;
  } verdict_t;

  verdict_t verdict_q[$];
  int unsigned errors = 0, verdicts_seen = 0, frames_sent = 0, beats_sent = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0, stall_pct = 0;

  // Predictor copy of the monitor state.
  logic [31:0] m_win, m_dth, m_bth;
  logic [11:0] m_pos;
  logic [7:0]  m_fc;
  logic        m_bcast;
  logic [47:0] m_bssid;
  wmam_pkg::phase_e m_ph;
  logic [7:0]  m_rem;
  logic [wmam_pkg::SsidBits-1:0] m_ssid;
  logic        m_found;
  int unsigned m_cap;
  logic [31:0] m_wstart;
  logic [15:0] m_dcnt, m_bcnt;
  logic [3:0]  m_flags;
  logic [wmam_pkg::SsidBits-1:0] m_tab_ssid[wmam_pkg::TableEntries];
  logic [47:0] m_tab_bssid[wmam_pkg::TableEntries];
  int unsigned m_seen;

  task automatic model_reset();
    m_win = 10; m_dth = 8; m_bth = 40;
    m_pos = 0; m_wstart = 0; m_dcnt = 0; m_bcnt = 0; m_flags = 0; m_seen = 0;
  endtask

  function automatic logic [3:0] raise(logic [3:0] bit_mask);
    if ((m_flags & bit_mask) != 0) return 4'b0;
    m_flags |= bit_mask;
    return bit_mask;
  endfunction

  // Update the monitor for an accepted frame; returns newly raised alerts.
  function automatic logic [3:0] update_monitor(logic [2:0] kind, logic [31:0] now);
    logic [31:0] win, dth, bth;
    logic [3:0] r;
    logic [wmam_pkg::SsidBits-1:0] s;
    logic ended, hit;
    logic [7:0] by;
    win = (m_win == 0) ? 32'd10 : m_win;
    dth = (m_dth == 0) ? 32'd8 : m_dth;
    bth = (m_bth == 0) ? 32'd40 : m_bth;
    r = 0;
    if (m_wstart == 0) m_wstart = now;
    if (32'(now - m_wstart) >= win) begin
      m_wstart = now; m_dcnt = 0; m_bcnt = 0;
    end
    if (kind == wmam_pkg::KindDeauth || kind == wmam_pkg::KindDisassoc) begin
      if (m_bcast) r |= raise(wmam_pkg::AlertBcast);
      if (m_dcnt != 16'hFFFF) m_dcnt++;
      if (32'(m_dcnt) >= dth) r |= raise(wmam_pkg::AlertDflood);
    end else if (kind == wmam_pkg::KindBeacon) begin
      if (m_bcnt != 16'hFFFF) m_bcnt++;
      if (32'(m_bcnt) >= bth) r |= raise(wmam_pkg::AlertBflood);
      if (m_found && m_ssid[7:0] != 0) begin
        ended = 0; s = '0; hit = 0;
        for (int k = 0; k < wmam_pkg::SsidMaxBytes; k++) begin
          by = m_ssid[k*8 +: 8];
          if (by == 0) ended = 1;
          if (!ended) s[k*8 +: 8] = by;
        end
        for (int i = 0; i < m_seen && !hit; i++)
          if (m_tab_ssid[i] == s) begin
            hit = 1;
            if (m_tab_bssid[i] != m_bssid) r |= raise(wmam_pkg::AlertTwin);
          end
        if (!hit && m_seen < wmam_pkg::TableEntries) begin
          m_tab_ssid[m_seen] = s; m_tab_bssid[m_seen] = m_bssid; m_seen++;
        end
      end
    end
    return r;
  endfunction

  // Feed one byte to the predictor; queues a verdict on the last byte.
  task automatic predict_byte(logic [7:0] b, logic last, logic [31:0] now);
    logic [11:0] pos;
    logic [3:0] st;
    verdict_t v;
    pos = m_pos;
    if (pos == 0) begin
      m_fc = b; m_bcast = 1; m_bssid = 0; m_ph = wmam_pkg::PH_ID; m_rem = 0;
      m_ssid = '0; m_found = 0; m_cap = 0;
    end
    if (pos >= 4 && pos <= 9 && b != 8'hFF) m_bcast = 0;
    if (pos >= 16 && pos <= 21) m_bssid[(pos-16)*8 +: 8] = b;
    // Tagged element walk from the body offset on
    if (pos >= 36) begin
      case (m_ph)
        wmam_pkg::PH_ID: m_ph = (b == 0) ? wmam_pkg::PH_SSID_LEN : wmam_pkg::PH_LEN;
        wmam_pkg::PH_LEN: begin
          m_rem = b; m_ph = (b != 0) ? wmam_pkg::PH_SKIP : wmam_pkg::PH_ID;
        end
        wmam_pkg::PH_SSID_LEN: begin
          m_rem = b; m_cap = 0;
          if (b == 0) begin m_found = 1; m_ph = wmam_pkg::PH_DONE; end
          else m_ph = wmam_pkg::PH_SSID_BODY;
        end
        wmam_pkg::PH_SKIP: begin
          m_rem--; if (m_rem == 0) m_ph = wmam_pkg::PH_ID;
        end
        wmam_pkg::PH_SSID_BODY: begin
          if (m_cap < wmam_pkg::SsidMaxBytes) begin
            m_ssid[m_cap*8 +: 8] = b; m_cap++;
          end
          m_rem--;
          if (m_rem == 0) begin m_found = 1; m_ph = wmam_pkg::PH_DONE; end
        end
        default: m_ph = wmam_pkg::PH_DONE;
      endcase
    end
    if (pos != 12'hFFF) m_pos = pos + 12'd1;
    if (last) begin
      v = '0; v.kind = wmam_pkg::KindOther;
      st = m_fc[7:4];
      if (pos >= 23 && m_fc[3:2] == 2'b00) begin
        v.accepted = 1;
        case (st)
          4'hC: v.kind = wmam_pkg::KindDeauth;
          4'hA: v.kind = wmam_pkg::KindDisassoc;
          4'h4: v.kind = wmam_pkg::KindProbe;
          4'h8: v.kind = wmam_pkg::KindBeacon;
          default: v.accepted = 0;
        endcase
      end
      if (v.accepted) v.fresh = update_monitor(v.kind, now);
      else v.kind = wmam_pkg::KindOther;
      v.held = m_flags;
      verdict_q.push_back(v);
      m_pos = 0;
    end
  endtask

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: random stall and result checking
  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {accepted_o, frame_kind_o, new_alerts_o, held_alerts_o};
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected verdict %h", $time, got);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (got.accepted !== want.accepted || got.kind !== want.kind ||
            got.fresh !== want.fresh || got.held !== want.held) begin
          $display("%0t verdict mismatch: expected acc=%0b kind=%0d new=%h held=%h",
                   $time, want.accepted, want.kind, want.fresh, want.held);
          $display("%0t                   actual   acc=%0b kind=%0d new=%h held=%h",
                   $time, got.accepted, got.kind, got.fresh, got.held);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Send one beat, holding it until taken; random idle cycles before it.
  task automatic send_beat(logic [7:0] b, logic last, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; frame_byte_i <= b; frame_end_i <= last; time_seconds_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b, last, now);
    beats_sent++;
    if (last) frames_sent++;
  endtask

  // Wait for every queued verdict, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      wmam_pkg::RegWindow: m_win = val;
      wmam_pkg::RegDeauth: m_dth = {16'b0, val[15:0]};
      wmam_pkg::RegBeacon: m_bth = {16'b0, val[15:0]};
      default: ;
    endcase
  endtask

  // Build and send a frame. ssid_len < 0 means no SSID element.
  task automatic send_frame(logic [3:0] subtype, logic [1:0] ftype, logic bcast,
                            logic [47:0] bssid, int ssid_len, int ssid_seed,
                            int body_extra, logic [31:0] now, int total_len = -1);
    logic [7:0] bytes[$];
    int n;
    bytes.push_back({subtype, ftype, 2'b00});
    for (int i = 1; i < 4; i++) bytes.push_back(8'($urandom_range(255)));
    for (int i = 0; i < 6; i++) bytes.push_back(bcast ? 8'hFF : 8'($urandom_range(254)));
    for (int i = 10; i < 16; i++) bytes.push_back(8'($urandom_range(255)));
    for (int i = 0; i < 6; i++) bytes.push_back(bssid[i*8 +: 8]);
    for (int i = 22; i < 36; i++) bytes.push_back(8'($urandom_range(255)));
    // A random non-SSID element first, sometimes
    if ($urandom_range(3) == 0) begin
      n = int'($urandom_range(6));
      bytes.push_back(8'($urandom_range(1, 255))); bytes.push_back(8'(n));
      for (int i = 0; i < n; i++) bytes.push_back(8'($urandom_range(255)));
    end
    if (ssid_len >= 0) begin
      bytes.push_back(8'h00); bytes.push_back(8'(ssid_len));
      for (int i = 0; i < ssid_len; i++)
        bytes.push_back(8'((ssid_seed * 7 + i * 13) % 251 + 1));
    end
    for (int i = 0; i < body_extra; i++) bytes.push_back(8'($urandom_range(255)));
    n = (total_len > 0) ? total_len : int'(bytes.size());
    for (int i = 0; i < n; i++)
      send_beat((i < bytes.size()) ? bytes[i] : 8'($urandom_range(255)), i == n - 1, now);
  endtask

  // Directed rows: kind, expected verdict where obvious
  typedef struct {
    logic [3:0] subtype;
    logic [1:0] ftype;
    logic       bcast;
    int         ssid_len;
    int         len;
    logic       check;
    verdict_t   want;
  } row_t;

  row_t rows[] = '{
    '{4'hC, 2'b00, 1'b1, -1, 24, 1'b1,
      '{1'b1, wmam_pkg::KindDeauth, wmam_pkg::AlertBcast, wmam_pkg::AlertBcast}},
    '{4'hA, 2'b00, 1'b0, -1, 24, 1'b1,
      '{1'b1, wmam_pkg::KindDisassoc, 4'h0, wmam_pkg::AlertBcast}},
    '{4'h4, 2'b00, 1'b1, -1, 30, 1'b1,
      '{1'b1, wmam_pkg::KindProbe, 4'h0, wmam_pkg::AlertBcast}},
    '{4'hC, 2'b00, 1'b1, -1, 23, 1'b1,
      '{1'b0, wmam_pkg::KindOther, 4'h0, wmam_pkg::AlertBcast}},
    '{4'hC, 2'b00, 1'b1, -1, 1, 1'b1,
      '{1'b0, wmam_pkg::KindOther, 4'h0, wmam_pkg::AlertBcast}},
    '{4'hC, 2'b10, 1'b1, -1, 24, 1'b1,
      '{1'b0, wmam_pkg::KindOther, 4'h0, wmam_pkg::AlertBcast}},
    '{4'h0, 2'b00, 1'b1, -1, 24, 1'b1,
      '{1'b0, wmam_pkg::KindOther, 4'h0, wmam_pkg::AlertBcast}},
    '{4'hF, 2'b11, 1'b1, -1, 24, 1'b1,
      '{1'b0, wmam_pkg::KindOther, 4'h0, wmam_pkg::AlertBcast}},
    '{4'h8, 2'b00, 1'b1, 5, -1, 1'b0, '0},
    '{4'h8, 2'b00, 1'b1, 5, -1, 1'b0, '0},
    '{4'h8, 2'b00, 1'b1, 0, -1, 1'b0, '0},
    '{4'h8, 2'b00, 1'b1, 32, -1, 1'b0, '0},
    '{4'h8, 2'b00, 1'b1, 40, -1, 1'b0, '0},
    '{4'h8, 2'b00, 1'b1, 20, 45, 1'b0, '0},
    '{4'h8, 2'b00, 1'b1, 255, -1, 1'b0, '0}
  };

  initial begin
    int sel, seed, len;
    logic [31:0] now;
    logic [47:0] bss[4];
    model_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, one frame per row
    now = 100;
    foreach (rows[r]) begin
      send_frame(rows[r].subtype, rows[r].ftype, rows[r].bcast,
                 48'h0000_1111_2222 + 48'(r), rows[r].ssid_len, 3, 0, now, rows[r].len);
      // Typed verdict stands in for the predicted one on the obvious rows
      if (rows[r].check) verdict_q[verdict_q.size() - 1] = rows[r].want;
    end
    // Evil twin with a known SSID
    send_frame(4'h8, 2'b00, 1'b0, 48'h99, 5, 3, 0, now + 1);
    drain();

    // Register extremes
    write_reg(wmam_pkg::RegWindow, 32'hFFFF_FFFF);
    write_reg(wmam_pkg::RegDeauth, 32'h0000_FFFF);
    write_reg(wmam_pkg::RegBeacon, 32'h0000_FFFF);
    for (int i = 0; i < 6; i++)
      send_frame(4'hC, 2'b00, 1'b0, 48'h1, -1, 0, 0, 32'hFFFF_FFF0 + 32'(i));
    drain();
    write_reg(wmam_pkg::RegWindow, 32'd0);
    write_reg(wmam_pkg::RegDeauth, 32'd0);
    write_reg(wmam_pkg::RegBeacon, 32'd0);

    // Random phases with different idling and settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      if (phase > 0) begin
        write_reg(wmam_pkg::RegWindow,
                  (phase == 4) ? 32'd1 : 32'($urandom_range(1, 30)));
        write_reg(wmam_pkg::RegDeauth,
                  (phase == 5) ? 32'd1 : 32'($urandom_range(1, 20)));
        write_reg(wmam_pkg::RegBeacon,
                  (phase == 6) ? 32'd1 : 32'($urandom_range(1, 60)));
      end
      for (int i = 0; i < 4; i++) bss[i] = 48'({$urandom, $urandom});
      now = $urandom;
      for (int f = 0; f < 2; f++) begin
        sel = int'($urandom_range(99));
        seed = int'($urandom_range(11));
        now += $urandom_range(3);
        len = int'($urandom_range(1, 12));
        if (sel < 40)
          send_frame(4'h8, 2'b00, 1'($urandom_range(1)), bss[$urandom_range(3)],
                     ($urandom_range(9) == 0) ? 0 : len, seed,
                     int'($urandom_range(3)), now);
        else if (sel < 70)
          send_frame($urandom_range(1) ? 4'hC : 4'hA, 2'b00, 1'($urandom_range(1)),
                     bss[0], -1, 0, int'($urandom_range(4)), now);
        else if (sel < 80)
          send_frame(4'h4, 2'b00, 1'b1, bss[1], len, seed, 0, now);
        else if (sel < 90)
          send_frame(4'($urandom), 2'($urandom), 1'($urandom_range(1)), bss[2],
                     -1, 0, 0, now, int'($urandom_range(1, 40)));
        else
          send_frame(4'h8, 2'b00, 1'b1, bss[3], 20, seed, 0, now,
                     int'($urandom_range(38, 56)));
      end
      drain();
    end

    $display("frames %0d, beats %0d, verdicts checked %0d, alerts held %h",
             frames_sent, beats_sent, verdicts_seen, m_flags);
    $display("covered rejects, all four kinds, SSID table, window wrap and idling phases");
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
